[hdl/ubx_frame_receiver_unit_defines.svh]
// assertion macros for the ubx frame receiver
// no dependencies; included by the top level only
`ifndef UBX_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define UBX_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define UBXFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubx frame receiver check failed");

// next-cycle implication, off during reset
`define UBXFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubx frame receiver check failed");

`endif

[hdl/ubxfr_pkg.sv]
// constants, types and message classification for the ubx frame receiver
// no dependencies
package ubxfr_pkg;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  localparam logic [15:0] NavPvtLen = 16'd92;
  localparam logic [15:0] TimTm2Len = 16'd28;

  localparam logic [7:0] ClsNav = 8'h01;
  localparam logic [7:0] IdPvt  = 8'h07;
  localparam logic [7:0] ClsTim = 8'h0D;
  localparam logic [7:0] IdTm2  = 8'h03;
  localparam logic [7:0] ClsCfg = 8'h06;
  localparam logic [7:0] IdValget = 8'h8B;
  localparam logic [7:0] ClsMon = 8'h0A;
  localparam logic [7:0] IdVer  = 8'h04;
  localparam logic [7:0] ClsAck = 8'h05;
  localparam logic [7:0] IdNak  = 8'h00;
  localparam logic [7:0] IdAck  = 8'h01;

  // parser phase, one-hot
  typedef enum logic [8:0] {
    ST_HUNT    = 9'b0_0000_0001,
    ST_SYNC2   = 9'b0_0000_0010,
    ST_CLASS   = 9'b0_0000_0100,
    ST_ID      = 9'b0_0000_1000,
    ST_LEN_LO  = 9'b0_0001_0000,
    ST_LEN_HI  = 9'b0_0010_0000,
    ST_PAYLOAD = 9'b0_0100_0000,
    ST_CK_A    = 9'b0_1000_0000,
    ST_CK_B    = 9'b1_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    MSG_UNKNOWN = 3'd0,
    MSG_MON_VER = 3'd1,
    MSG_NAV_PVT = 3'd2,
    MSG_TIM_TM2 = 3'd3,
    MSG_VALGET  = 3'd4,
    MSG_ACK     = 3'd5
  } msg_type_t;

  // message type from class, id and payload length
  function automatic msg_type_t classify(input logic [7:0] cls, input logic [7:0] id,
                                         input logic [15:0] len);
    msg_type_t t;
    t = MSG_UNKNOWN;
    priority if (cls == ClsNav && id == IdPvt && len == NavPvtLen) t = MSG_NAV_PVT;
    else if (cls == ClsTim && id == IdTm2 && len == TimTm2Len)     t = MSG_TIM_TM2;
    else if (cls == ClsCfg && id == IdValget)                      t = MSG_VALGET;
    else if (cls == ClsMon && id == IdVer)                         t = MSG_MON_VER;
    else if (cls == ClsAck && (id == IdNak || id == IdAck))        t = MSG_ACK;
    else                                                           t = MSG_UNKNOWN;
    return t;
  endfunction

endpackage

[hdl/ubxfr_ifs.sv]
// valid/ready channels for received bytes and decoded frame headers
// no dependencies
interface ubxfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubxfr_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_length;
  logic [2:0]  msg_type;

  modport source (output valid, output msg_class, output msg_id, output payload_length,
                  output msg_type, input ready);
  modport sink (input valid, input msg_class, input msg_id, input payload_length,
                input msg_type, output ready);
endinterface

[hdl/ubx_frame_receiver_unit.sv]
// ubx frame receiver: sync hunt, header parse, fletcher-8 check, type decode
// depends on ubxfr_pkg, ubxfr_ifs and ubx_frame_receiver_unit_defines.svh
//
// Usage:
//   rx  - byte channel in; one received byte per request (valid/ready).
//   res - one request per good frame: class, id, payload length, type code.
// Every byte is parsed in the cycle it is taken; a frame's result appears
// on res in the cycle after its second checksum byte is taken.
// Throughput is one byte per cycle unless rx.ready is low, set by the single
// phase register and running checksum update. Payload bytes only feed the checksum.
// The result sits in an output register. While it waits, bytes that cannot
// finish a frame are still taken; only a second checksum byte is held off
// (rx.ready low) until res drains, so the stall reaches rx only then.
// Frames with a bad sync or a bad checksum give no result.
// Reset (rst, synchronous) returns the parser to the sync hunt and
// empties the output register.
`include "ubx_frame_receiver_unit_defines.svh"

module ubx_frame_receiver_unit (
  input  logic                 clk,
  input  logic                 rst,
  ubxfr_byte_if.sink           rx,
  ubxfr_frame_if.source        res
);

  ubxfr_pkg::state_t state, state_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  held_class;
  logic [7:0]  held_id;
  logic [15:0] frame_length;
  logic [15:0] payload_count;
  logic [15:0] count_inc;
  logic        in_accept;
  logic        frame_good;
  logic        res_valid;

  // only a second checksum byte needs room in the output register
  assign rx.ready  = !res_valid || res.ready || (state != ubxfr_pkg::ST_CK_B);
  assign in_accept = rx.valid && rx.ready;

  // running fletcher sum including the current byte
  assign sum_a_next = sum_a + rx.rx_byte;
  assign sum_b_next = sum_b + sum_a_next;
  assign count_inc  = payload_count + 16'd1;
  assign frame_good = in_accept && (state == ubxfr_pkg::ST_CK_B) && (rx.rx_byte == sum_b);

  // next phase
  always_comb begin
    state_next = state;
    unique case (state)
      ubxfr_pkg::ST_HUNT:
        if (rx.rx_byte == ubxfr_pkg::SyncFirst) state_next = ubxfr_pkg::ST_SYNC2;
      ubxfr_pkg::ST_SYNC2:
        state_next = (rx.rx_byte == ubxfr_pkg::SyncSecond) ? ubxfr_pkg::ST_CLASS
                                                           : ubxfr_pkg::ST_HUNT;
      ubxfr_pkg::ST_CLASS:  state_next = ubxfr_pkg::ST_ID;
      ubxfr_pkg::ST_ID:     state_next = ubxfr_pkg::ST_LEN_LO;
      ubxfr_pkg::ST_LEN_LO: state_next = ubxfr_pkg::ST_LEN_HI;
      ubxfr_pkg::ST_LEN_HI:
        state_next = ({rx.rx_byte, frame_length[7:0]} != 16'd0) ? ubxfr_pkg::ST_PAYLOAD
                                                                : ubxfr_pkg::ST_CK_A;
      ubxfr_pkg::ST_PAYLOAD:
        if (count_inc == frame_length) state_next = ubxfr_pkg::ST_CK_A;
      ubxfr_pkg::ST_CK_A:
        state_next = (rx.rx_byte == sum_a) ? ubxfr_pkg::ST_CK_B : ubxfr_pkg::ST_HUNT;
      ubxfr_pkg::ST_CK_B:   state_next = ubxfr_pkg::ST_HUNT;
      default:              state_next = ubxfr_pkg::ST_HUNT;
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ubxfr_pkg::ST_HUNT;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // checksum, header fields and payload counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a         <= '0;
      sum_b         <= '0;
      held_class    <= '0;
      held_id       <= '0;
      frame_length  <= '0;
      payload_count <= '0;
    end else if (in_accept) begin
      unique case (state)
        ubxfr_pkg::ST_HUNT:
          if (rx.rx_byte == ubxfr_pkg::SyncFirst) begin
            sum_a         <= '0;
            sum_b         <= '0;
            payload_count <= '0;
          end
        ubxfr_pkg::ST_CLASS: begin
          held_class <= rx.rx_byte;
          sum_a      <= sum_a_next;
          sum_b      <= sum_b_next;
        end
        ubxfr_pkg::ST_ID: begin
          held_id <= rx.rx_byte;
          sum_a   <= sum_a_next;
          sum_b   <= sum_b_next;
        end
        ubxfr_pkg::ST_LEN_LO: begin
          frame_length <= {8'd0, rx.rx_byte};
          sum_a        <= sum_a_next;
          sum_b        <= sum_b_next;
        end
        ubxfr_pkg::ST_LEN_HI: begin
          frame_length  <= {rx.rx_byte, frame_length[7:0]};
          sum_a         <= sum_a_next;
          sum_b         <= sum_b_next;
          payload_count <= '0;
        end
        ubxfr_pkg::ST_PAYLOAD: begin
          sum_a         <= sum_a_next;
          sum_b         <= sum_b_next;
          payload_count <= count_inc;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (frame_good) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_good) begin
      res.msg_class      <= held_class;
      res.msg_id         <= held_id;
      res.payload_length <= frame_length;
      res.msg_type       <= ubxfr_pkg::classify(held_class, held_id, frame_length);
    end
  end

  assign res.valid = res_valid;

  // checks
  `UBXFR_ASSERT_NEXT(a_good_frame_gives_result, clk, rst, frame_good, res_valid)
  `UBXFR_ASSERT_NOW(a_stall_only_on_last_byte, clk, rst, !rx.ready,
                    (state == ubxfr_pkg::ST_CK_B) && res_valid)
  `UBXFR_ASSERT_NEXT(a_hunt_ignores_noise, clk, rst,
                     in_accept && (state == ubxfr_pkg::ST_HUNT) &&
                     (rx.rx_byte != ubxfr_pkg::SyncFirst),
                     state == ubxfr_pkg::ST_HUNT)

endmodule

[bench/ubxfr_header_check.sv]
`timescale 1ns / 100ps
// checker for the ubx frame receiver: watches the byte and result channels,
// predicts each good frame's header and type, compares in order
// depends on ubxfr_pkg and ubxfr_ifs
module ubxfr_header_check (
  input  logic        clk,
  input  logic        rst,
  ubxfr_byte_if       rx,
  ubxfr_frame_if      res,
  output int unsigned fail_count,
  output int unsigned pending
);
  import ubxfr_pkg::*;

  typedef struct packed {
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    msg_type_t   msg_type;
  } frame_header_t;

  frame_header_t expected_headers[$];

  // parser copy
  state_t      hunt_state;
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;
  logic [7:0]  hdr_class;
  logic [7:0]  hdr_id;
  logic [15:0] hdr_len;
  logic [15:0] body_seen;

  // type from class and id; two types also need their exact length
  function automatic msg_type_t decode_type(input logic [7:0] c, input logic [7:0] i,
                                            input logic [15:0] n);
    if (c == ClsNav && i == IdPvt) return (n == NavPvtLen) ? MSG_NAV_PVT : MSG_UNKNOWN;
    if (c == ClsTim && i == IdTm2) return (n == TimTm2Len) ? MSG_TIM_TM2 : MSG_UNKNOWN;
    if (c == ClsCfg && i == IdValget) return MSG_VALGET;
    if (c == ClsMon && i == IdVer) return MSG_MON_VER;
    if (c == ClsAck && (i == IdNak || i == IdAck)) return MSG_ACK;
    return MSG_UNKNOWN;
  endfunction

  task automatic fold_sum(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endtask

  // one byte through the parser copy
  task automatic parse_byte(input logic [7:0] b);
    frame_header_t hdr;
    case (hunt_state)
      ST_HUNT: begin
        if (b == SyncFirst) begin
          fl_a = 8'h00;
          fl_b = 8'h00;
          body_seen = 16'h0000;
          hunt_state = ST_SYNC2;
        end
      end
      ST_SYNC2: hunt_state = (b == SyncSecond) ? ST_CLASS : ST_HUNT;
      ST_CLASS: begin
        hdr_class = b;
        fold_sum(b);
        hunt_state = ST_ID;
      end
      ST_ID: begin
        hdr_id = b;
        fold_sum(b);
        hunt_state = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        hdr_len = {8'h00, b};
        fold_sum(b);
        hunt_state = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        hdr_len[15:8] = b;
        fold_sum(b);
        body_seen = 16'h0000;
        hunt_state = (hdr_len != 16'h0000) ? ST_PAYLOAD : ST_CK_A;
      end
      ST_PAYLOAD: begin
        fold_sum(b);
        body_seen = body_seen + 16'd1;
        if (body_seen == hdr_len) hunt_state = ST_CK_A;
      end
      ST_CK_A: hunt_state = (b == fl_a) ? ST_CK_B : ST_HUNT;
      ST_CK_B: begin
        hunt_state = ST_HUNT;
        if (b == fl_b) begin
          hdr.msg_class = hdr_class;
          hdr.msg_id = hdr_id;
          hdr.payload_length = hdr_len;
          hdr.msg_type = decode_type(hdr_class, hdr_id, hdr_len);
          expected_headers.push_back(hdr);
        end
      end
      default: hunt_state = ST_HUNT;
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // result request against the oldest prediction
  task automatic compare_header();
    frame_header_t want;
    if (expected_headers.size() == 0) begin
      note_failure($sformatf("unexpected frame class %02h id %02h len %0d type %0d",
                             res.msg_class, res.msg_id, res.payload_length, res.msg_type));
    end else begin
      want = expected_headers.pop_front();
      if (res.msg_class !== want.msg_class || res.msg_id !== want.msg_id ||
          res.payload_length !== want.payload_length || res.msg_type !== want.msg_type) begin
        note_failure($sformatf({"frame mismatch: expected class %02h id %02h len %0d type %0d,",
                                " got class %02h id %02h len %0d type %0d"},
                               want.msg_class, want.msg_id, want.payload_length,
                               want.msg_type, res.msg_class, res.msg_id,
                               res.payload_length, res.msg_type));
      end
    end
  endtask

  // results first, then the byte taken on the same edge
  always @(posedge clk) begin
    if (rst) begin
      hunt_state = ST_HUNT;
      fl_a = 8'h00;
      fl_b = 8'h00;
      hdr_class = 8'h00;
      hdr_id = 8'h00;
      hdr_len = 16'h0000;
      body_seen = 16'h0000;
      fail_count = 0;
      expected_headers.delete();
    end else begin
      if (res.valid && res.ready) compare_header();
      if (rx.valid && rx.ready) parse_byte(rx.rx_byte);
    end
    pending = expected_headers.size();
  end

endmodule

[bench/tb_ubx_frame_receiver_unit.sv]
`timescale 1ns / 100ps
// top of the ubx frame receiver bench: clock, reset, byte stimulus, result stalls
// depends on ubxfr_pkg, ubxfr_ifs, ubx_frame_receiver_unit and ubxfr_header_check
module tb_ubx_frame_receiver_unit;
  import ubxfr_pkg::*;

  localparam int unsigned CycleLimit = 600_000;
  localparam int unsigned ByteTarget = 1400;
  localparam int unsigned QuietAfter = 1150;

  logic        clk = 1'b0;
  logic        rst;
  logic        quiet = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned stall_left;
  logic [7:0]  run_a;
  logic [7:0]  run_b;

  ubxfr_byte_if  rx_if ();
  ubxfr_frame_if res_if ();

  ubx_frame_receiver_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if)
  );

  ubxfr_header_check header_check (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("ubx_frame_receiver_unit verification failed");
      $finish;
    end
  end

  // result side stalls in short bursts
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      res_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // one byte request, with an occasional gap in front
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_summed(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
    send_byte(b);
  endtask

  // whole frame; a nonzero flip corrupts that checksum byte
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input logic [7:0] flip_a,
                            input logic [7:0] flip_b);
    run_a = 8'h00;
    run_b = 8'h00;
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_summed(cls);
    send_summed(id);
    send_summed(len[7:0]);
    send_summed(len[15:8]);
    for (int unsigned k = 0; k < len; k++) send_summed(8'($urandom_range(0, 255)));
    send_byte(run_a ^ flip_a);
    if (flip_a == 8'h00) send_byte(run_b ^ flip_b);
  endtask

  // header biased toward the decoded message types
  task automatic random_frame(input logic [7:0] flip_a, input logic [7:0] flip_b);
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    cls = 8'($urandom_range(0, 255));
    id = 8'($urandom_range(0, 255));
    len = 16'($urandom_range(0, 24));
    case ($urandom_range(0, 7))
      0: begin
        cls = ClsNav;
        id = IdPvt;
        if ($urandom_range(0, 1) != 0) len = NavPvtLen;
      end
      1: begin
        cls = ClsTim;
        id = IdTm2;
        if ($urandom_range(0, 1) != 0) len = TimTm2Len;
      end
      2: begin
        cls = ClsCfg;
        id = IdValget;
      end
      3: begin
        cls = ClsMon;
        id = IdVer;
      end
      4: begin
        cls = ClsAck;
        id = ($urandom_range(0, 1) != 0) ? IdAck : IdNak;
      end
      5: cls = ClsAck;
      default: ;
    endcase
    // now and then a length with the high byte set
    if ($urandom_range(0, 49) == 0) len = 16'($urandom_range(256, 300));
    send_frame(cls, id, len, flip_a, flip_b);
  endtask

  // hold the sender until every predicted frame has come out
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned kind;
    logic [7:0]  b;
    logic        drained;
    drained = 1'b0;
    rst <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero-length acknowledge goes straight to the checksum
    send_frame(ClsAck, IdAck, 16'h0000, 8'h00, 8'h00);
    // repeated first sync byte is not a new start, so the 0x62 is ignored
    send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    // all-ones header, bad checksum A equal to the first sync byte (sum is 0xfe), not taken as a new start
    send_frame(8'hFF, 8'hFF, 16'h0000, 8'h4B, 8'h00);
    send_byte(SyncSecond);
    // all-zero header, bad checksum B
    send_frame(8'h00, 8'h00, 16'h0000, 8'h00, 8'h80);

    // random frames, bad checksums and line noise
    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= QuietAfter) quiet <= 1'b1;
      if (!drained && bytes_sent >= ByteTarget / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        random_frame(8'h00, 8'h00);
      end else if (kind < 78) begin
        random_frame(8'($urandom_range(1, 255)), 8'h00);
      end else if (kind < 86) begin
        random_frame(8'h00, 8'($urandom_range(1, 255)));
      end else if (kind < 93) begin
        b = 8'($urandom_range(0, 255));
        if (b == SyncSecond) b = b ^ 8'h01;
        send_byte(SyncFirst);
        send_byte(b);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ubx_frame_receiver_unit verification clean");
    end else begin
      $display("ubx_frame_receiver_unit verification failed");
    end
    $finish;
  end

endmodule
